[hdl/obrb_pkg.sv]
package obrb_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 64;
  localparam int CFG_W         = 9;
  localparam int BYTE_W        = 8;
  localparam int REQ_W         = 3;
  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 3'd0,
    REQ_PEEK    = 3'd1,
    REQ_READ    = 3'd2,
    REQ_CONSUME = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } state_t;

  typedef struct packed {
    logic single_load;
    logic burst_start;
    logic load_byte;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic rd_pend;
    logic n_zero;
    logic iss_left_zero;
    logic out_left_one;
  } status_t;

endpackage

[hdl/obrb_ctrl.sv]
module obrb_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [obrb_pkg::REQ_W-1:0] req_type,
  input  logic                    out_ready,
  input  obrb_pkg::status_t       st,
  output obrb_pkg::cmd_t          cmd
);
  import obrb_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   is_burst_req;

  assign slot_free    = !st.out_valid || out_ready;
  assign is_burst_req = (req_type == REQ_PEEK) || (req_type == REQ_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (is_burst_req && !st.n_zero) begin
            cmd.burst_start = 1'b1;
            state_next      = ST_BURST;
          end else begin
            cmd.single_load = 1'b1;
          end
        end
      end
      ST_BURST: begin
        cmd.load_byte = st.rd_pend && slot_free;
        cmd.issue     = !st.iss_left_zero && (!st.rd_pend || cmd.load_byte);
        if (cmd.load_byte && st.out_left_one) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/obrb_dp.sv]
module obrb_dp #(
  parameter int DEPTH     = obrb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = obrb_pkg::MAX_BURST_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  obrb_pkg::cmd_t             cmd,
  output obrb_pkg::status_t          st,
  input  logic                       cfg_write,
  input  logic [obrb_pkg::CFG_W-1:0] cfg_data,
  input  logic [obrb_pkg::REQ_W-1:0] req_type,
  input  logic [obrb_pkg::BYTE_W-1:0] data_in,
  input  logic [obrb_pkg::BYTE_W-1:0] count,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [obrb_pkg::BYTE_W-1:0] data_out,
  output logic                       has_data,
  output logic                       is_last,
  output logic [obrb_pkg::BYTE_W-1:0] bytes_available,
  output logic [obrb_pkg::BYTE_W-1:0] free_space
);
  import obrb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
  localparam int BW = $clog2(MAX_BURST + 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic [CFG_W-1:0]  cfg_size;
  logic [PW-1:0]     w_idx;
  logic [PW-1:0]     r_idx;
  logic [PW-1:0]     w_idx_next;
  logic [PW-1:0]     r_idx_next;
  logic [PW-1:0]     pos;
  logic [BW-1:0]     iss_left;
  logic [BW-1:0]     out_left;
  logic              rd_pend;
  logic [BYTE_W-1:0] burst_avail;
  logic [BYTE_W-1:0] burst_free;

  logic [XW-1:0] s;
  logic [XW-1:0] size_x;
  logic [XW-1:0] w_x;
  logic [XW-1:0] r_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] lim;
  logic [XW-1:0] avail;
  logic [XW-1:0] n_b0;
  logic [XW-1:0] n_b;
  logic [XW-1:0] n_c;
  logic [XW-1:0] n;
  logic [XW-1:0] sum;
  logic [XW-1:0] r_adv;
  logic [XW-1:0] after;
  logic [XW-1:0] free_x;
  logic          accept;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          wr_en;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [XW-1:0] sz);
    logic [XW-1:0] nx;
    nx = {{(XW-PW){1'b0}}, p} + XW'(1);
    adv = (nx >= sz) ? '0 : nx[PW-1:0];
  endfunction

  // slots in use, clamped to 2..DEPTH
  assign size_x = XW'(cfg_size);
  always_comb begin
    if (size_x < XW'(2)) begin
      s = XW'(2);
    end else if (size_x > XW'(DEPTH)) begin
      s = XW'(DEPTH);
    end else begin
      s = size_x;
    end
  end

  assign w_x   = {{(XW-PW){1'b0}}, w_idx};
  assign r_x   = {{(XW-PW){1'b0}}, r_idx};
  assign cnt_x = {{(XW-BYTE_W){1'b0}}, count};
  assign lim   = XW'(MAX_BURST);
  assign avail = (w_x >= r_x) ? (w_x - r_x) : (s - r_x + w_x);
  assign n_b0  = (cnt_x > lim) ? lim : cnt_x;
  assign n_b   = (n_b0 > avail) ? avail : n_b0;
  assign n_c   = (cnt_x > avail) ? avail : cnt_x;
  assign n     = (req_type == REQ_CONSUME) ? n_c : n_b;
  assign sum   = r_x + n;
  assign r_adv = (sum >= s) ? (sum - s) : sum;

  always_comb begin
    case (req_type)
      REQ_WRITE:   after = (avail == s - XW'(1)) ? avail : avail + XW'(1);
      REQ_PEEK:    after = avail;
      REQ_READ:    after = avail - n;
      REQ_CONSUME: after = avail - n;
      REQ_CLEAR:   after = '0;
      default:     after = avail;
    endcase
  end
  assign free_x = s - after - XW'(1);

  assign accept = cmd.single_load || cmd.burst_start;
  assign wr_en  = cmd.single_load && (req_type == REQ_WRITE);

  always_comb begin
    w_idx_next = w_idx;
    r_idx_next = r_idx;
    case (req_type)
      REQ_WRITE: begin
        w_idx_next = adv(w_idx, s);
        if (w_idx_next == r_idx) begin
          r_idx_next = adv(r_idx, s);
        end
      end
      REQ_READ:    r_idx_next = r_adv[PW-1:0];
      REQ_CONSUME: r_idx_next = r_adv[PW-1:0];
      REQ_CLEAR:   r_idx_next = w_idx;
      default:     r_idx_next = r_idx;
    endcase
  end

  assign rd_en   = cmd.burst_start || cmd.issue;
  assign rd_addr = cmd.burst_start ? r_idx : pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[w_idx] <= data_in;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size <= SIZE_RESET;
      w_idx    <= '0;
      r_idx    <= '0;
    end else if (cfg_write) begin
      cfg_size <= cfg_data;
      w_idx    <= '0;
      r_idx    <= '0;
    end else if (accept) begin
      w_idx <= w_idx_next;
      r_idx <= r_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      iss_left  <= '0;
      out_left  <= '0;
    end else begin
      if (cmd.burst_start || cmd.issue) begin
        rd_pend <= 1'b1;
      end else if (cmd.load_byte) begin
        rd_pend <= 1'b0;
      end
      if (cmd.burst_start) begin
        iss_left <= BW'(n_b - XW'(1));
        out_left <= BW'(n_b);
      end else begin
        if (cmd.issue) begin
          iss_left <= iss_left - BW'(1);
        end
        if (cmd.load_byte) begin
          out_left <= out_left - BW'(1);
        end
      end
      if (cmd.single_load || cmd.load_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.burst_start) begin
      pos         <= adv(r_idx, s);
      burst_avail <= after[BYTE_W-1:0];
      burst_free  <= free_x[BYTE_W-1:0];
    end else if (cmd.issue) begin
      pos <= adv(pos, s);
    end
    if (cmd.single_load) begin
      data_out        <= '0;
      has_data        <= 1'b0;
      is_last         <= 1'b1;
      bytes_available <= after[BYTE_W-1:0];
      free_space      <= free_x[BYTE_W-1:0];
    end else if (cmd.load_byte) begin
      data_out        <= rdata;
      has_data        <= 1'b1;
      is_last         <= (out_left == BW'(1));
      bytes_available <= burst_avail;
      free_space      <= burst_free;
    end
  end

  assign st.out_valid     = out_valid;
  assign st.rd_pend       = rd_pend;
  assign st.n_zero        = (n_b == '0);
  assign st.iss_left_zero = (iss_left == '0);
  assign st.out_left_one  = (out_left == BW'(1));

endmodule

[hdl/overwriting_byte_ring_buffer.sv]
// channel   signals                                     payload
// in        in_valid / in_ready                         req_type, data_in, count
// out       out_valid / out_ready                       data_out, has_data, is_last,
//                                                       bytes_available, free_space
// cfg       cfg_valid / cfg_ready (always ready)        cfg_data (buffer size)
//
// write, consume, clear and empty peek/read requests give one result each;
// the next request is taken once that result leaves or is leaving.
// peek/read of n bytes streams one byte a cycle through the
// registered read port of the byte store while out_ready stays high.
// synchronous reset clears positions and sets the size to 256; no clearing pass.
// a stall on out holds the result register and stops further store reads.
module overwriting_byte_ring_buffer #(
  parameter int DEPTH     = obrb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = obrb_pkg::MAX_BURST_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [obrb_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [obrb_pkg::REQ_W-1:0]  req_type,
  input  logic [obrb_pkg::BYTE_W-1:0] data_in,
  input  logic [obrb_pkg::BYTE_W-1:0] count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [obrb_pkg::BYTE_W-1:0] data_out,
  output logic                        has_data,
  output logic                        is_last,
  output logic [obrb_pkg::BYTE_W-1:0] bytes_available,
  output logic [obrb_pkg::BYTE_W-1:0] free_space
);
  import obrb_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  obrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  obrb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .data_in         (data_in),
    .count           (count),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .data_out        (data_out),
    .has_data        (has_data),
    .is_last         (is_last),
    .bytes_available (bytes_available),
    .free_space      (free_space)
  );

  // a result without a byte always ends its request
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> is_last)
    else $error("result without data not marked last");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.single_load, cmd.burst_start, cmd.load_byte}))
    else $error("conflicting result loads");

  // no store read left over once the last byte is loaded
  a_burst_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte && st.out_left_one |=> !st.rd_pend)
    else $error("store read pending after last byte");

endmodule
